@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define TRPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define TRPC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `TRPC_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

@@ rtl/trpc_pkg.sv @@
// types and constants of the transaction record parser and checker
// used by every module of the block; no dependencies
package trpc_pkg;

  localparam int unsigned KEY_BYTES   = 33;
  localparam int unsigned SIG_BYTES   = 64;
  localparam int unsigned MIN_RECORD  = 4 + 2 + 4 + KEY_BYTES + 8 + 8 + 4 + 2;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] MAGIC_0 = 8'h44;  // D
  localparam logic [7:0] MAGIC_1 = 8'h4E;  // N
  localparam logic [7:0] MAGIC_2 = 8'h54;  // T
  localparam logic [7:0] MAGIC_3 = 8'h58;  // X

  localparam int unsigned OUT_TDATA_W = 192;

  typedef enum logic [1:0] {
    REG_VERSION = 2'd0,
    REG_CHAIN   = 2'd1,
    REG_MAX_PAY = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_KEY     = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_SIG     = 2'd2,
    KIND_VERDICT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_VERSION   = 3'd3,
    ST_CHAIN     = 3'd4,
    ST_PAY_LEN   = 3'd5,
    ST_SIG_LEN   = 3'd6,
    ST_TRAILING  = 3'd7
  } status_t;

  typedef enum logic [11:0] {
    PH_MAGIC   = 12'b0000_0000_0001,
    PH_VERSION = 12'b0000_0000_0010,
    PH_CHAIN   = 12'b0000_0000_0100,
    PH_KEY     = 12'b0000_0000_1000,
    PH_NONCE   = 12'b0000_0001_0000,
    PH_FEE     = 12'b0000_0010_0000,
    PH_PAYLEN  = 12'b0000_0100_0000,
    PH_PAYLOAD = 12'b0000_1000_0000,
    PH_SIGLEN  = 12'b0001_0000_0000,
    PH_SIG     = 12'b0010_0000_0000,
    PH_DONE    = 12'b0100_0000_0000,
    PH_DRAIN   = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [15:0] expected_version;
    logic [31:0] expected_chain;
    logic [31:0] max_payload_len;
  } cfg_t;

  // results caused by one input beat: an optional streamed byte, then an optional verdict
  typedef struct packed {
    logic        stream_vld;
    kind_t       stream_kind;
    logic [7:0]  stream_byte;
    logic        verdict_vld;
    logic [63:0] nonce_value;
    logic [63:0] fee_value;
    logic [31:0] payload_length;
    logic [15:0] signature_length;
    status_t     status;
  } pair_t;

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = MAGIC_0;
      2'd1:    val = MAGIC_1;
      2'd2:    val = MAGIC_2;
      default: val = MAGIC_3;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/trpc_cfg_regs.sv @@
// configuration registers behind the apb-style port
// depends on trpc_pkg
module trpc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output trpc_pkg::cfg_t    cfg
);

  logic [15:0] version_r;
  logic [31:0] chain_r;
  logic [31:0] max_pay_r;
  logic        wr_en;
  trpc_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = trpc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= 16'd1;
      chain_r   <= 32'd1;
      max_pay_r <= 32'd65536;
    end else if (wr_en) begin
      case (idx)
        trpc_pkg::REG_VERSION: version_r <= pwdata[15:0];
        trpc_pkg::REG_CHAIN:   chain_r   <= pwdata;
        trpc_pkg::REG_MAX_PAY: max_pay_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      trpc_pkg::REG_VERSION: prdata = {16'd0, version_r};
      trpc_pkg::REG_CHAIN:   prdata = chain_r;
      trpc_pkg::REG_MAX_PAY: prdata = max_pay_r;
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg.expected_version = version_r;
  assign cfg.expected_chain   = chain_r;
  assign cfg.max_payload_len  = max_pay_r;

endmodule

@@ rtl/trpc_parser.sv @@
// per-byte record parser: field tracking, checks and result generation
// depends on trpc_pkg
module trpc_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  trpc_pkg::cfg_t    cfg,
  input  logic              take_en,
  input  logic [7:0]        data_byte,
  input  logic              frame_end,
  output trpc_pkg::pair_t   res
);

  trpc_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] field_count_r, field_count_nxt;
  logic [31:0] total_count_r, total_count_nxt;
  logic [63:0] field_shift_r, field_shift_nxt;
  logic [63:0] nonce_r, nonce_nxt;
  logic [63:0] fee_r, fee_nxt;
  logic [31:0] pay_len_r, pay_len_nxt;
  logic [15:0] sig_len_r, sig_len_nxt;
  trpc_pkg::status_t first_err_r, first_err_nxt;

  logic [32:0] fc_inc;
  logic [63:0] shift_add;
  logic        is_fail;
  trpc_pkg::status_t fail_code;
  trpc_pkg::status_t verdict_st;

  assign fc_inc    = {1'b0, field_count_r} + 33'd1;
  assign shift_add = field_shift_r | (64'(data_byte) << {field_count_r[2:0], 3'b000});

  always_comb begin
    phase_nxt       = phase_r;
    field_count_nxt = fc_inc[31:0];
    total_count_nxt = (total_count_r == 32'hFFFF_FFFF) ? total_count_r : total_count_r + 32'd1;
    field_shift_nxt = shift_add;
    nonce_nxt       = nonce_r;
    fee_nxt         = fee_r;
    pay_len_nxt     = pay_len_r;
    sig_len_nxt     = sig_len_r;
    first_err_nxt   = first_err_r;
    is_fail         = 1'b0;
    fail_code       = trpc_pkg::ST_OK;
    res             = '0;
    res.stream_kind = trpc_pkg::KIND_KEY;
    res.status      = trpc_pkg::ST_OK;

    case (phase_r)
      trpc_pkg::PH_MAGIC: begin
        field_shift_nxt = field_shift_r;
        if (data_byte != trpc_pkg::magic_byte(field_count_r[1:0])) begin
          is_fail   = 1'b1;
          fail_code = trpc_pkg::ST_MAGIC;
        end else if (fc_inc >= 33'd4) begin
          phase_nxt = trpc_pkg::PH_VERSION;
        end
      end
      trpc_pkg::PH_VERSION: begin
        if (fc_inc >= 33'd2) begin
          if (shift_add[15:0] != cfg.expected_version) begin
            is_fail   = 1'b1;
            fail_code = trpc_pkg::ST_VERSION;
          end else begin
            phase_nxt = trpc_pkg::PH_CHAIN;
          end
        end
      end
      trpc_pkg::PH_CHAIN: begin
        if (fc_inc >= 33'd4) begin
          if (shift_add[31:0] != cfg.expected_chain) begin
            is_fail   = 1'b1;
            fail_code = trpc_pkg::ST_CHAIN;
          end else begin
            phase_nxt = trpc_pkg::PH_KEY;
          end
        end
      end
      trpc_pkg::PH_KEY: begin
        field_shift_nxt = field_shift_r;
        res.stream_vld  = 1'b1;
        res.stream_kind = trpc_pkg::KIND_KEY;
        res.stream_byte = data_byte;
        if (fc_inc >= 33'(trpc_pkg::KEY_BYTES)) begin
          phase_nxt = trpc_pkg::PH_NONCE;
        end
      end
      trpc_pkg::PH_NONCE: begin
        if (fc_inc >= 33'd8) begin
          nonce_nxt = shift_add;
          phase_nxt = trpc_pkg::PH_FEE;
        end
      end
      trpc_pkg::PH_FEE: begin
        if (fc_inc >= 33'd8) begin
          fee_nxt   = shift_add;
          phase_nxt = trpc_pkg::PH_PAYLEN;
        end
      end
      trpc_pkg::PH_PAYLEN: begin
        if (fc_inc >= 33'd4) begin
          pay_len_nxt = shift_add[31:0];
          if (shift_add[31:0] > cfg.max_payload_len) begin
            is_fail   = 1'b1;
            fail_code = trpc_pkg::ST_PAY_LEN;
          end else if (shift_add[31:0] == 32'd0) begin
            phase_nxt = trpc_pkg::PH_SIGLEN;
          end else begin
            phase_nxt = trpc_pkg::PH_PAYLOAD;
          end
        end
      end
      trpc_pkg::PH_PAYLOAD: begin
        field_shift_nxt = field_shift_r;
        res.stream_vld  = 1'b1;
        res.stream_kind = trpc_pkg::KIND_PAYLOAD;
        res.stream_byte = data_byte;
        if (fc_inc >= {1'b0, pay_len_r}) begin
          phase_nxt = trpc_pkg::PH_SIGLEN;
        end
      end
      trpc_pkg::PH_SIGLEN: begin
        if (fc_inc >= 33'd2) begin
          sig_len_nxt = shift_add[15:0];
          if (shift_add[15:0] != 16'd0 && shift_add[15:0] != 16'(trpc_pkg::SIG_BYTES)) begin
            is_fail   = 1'b1;
            fail_code = trpc_pkg::ST_SIG_LEN;
          end else if (shift_add[15:0] == 16'd0) begin
            phase_nxt = trpc_pkg::PH_DONE;
          end else begin
            phase_nxt = trpc_pkg::PH_SIG;
          end
        end
      end
      trpc_pkg::PH_SIG: begin
        field_shift_nxt = field_shift_r;
        res.stream_vld  = 1'b1;
        res.stream_kind = trpc_pkg::KIND_SIG;
        res.stream_byte = data_byte;
        if (fc_inc >= 33'(sig_len_r)) begin
          phase_nxt = trpc_pkg::PH_DONE;
        end
      end
      trpc_pkg::PH_DONE: begin
        is_fail   = 1'b1;
        fail_code = trpc_pkg::ST_TRAILING;
      end
      default: begin
        // draining: only the byte count moves
        field_count_nxt = field_count_r;
        field_shift_nxt = field_shift_r;
      end
    endcase

    // a phase change restarts field assembly
    if (is_fail) begin
      phase_nxt = trpc_pkg::PH_DRAIN;
      if (first_err_r == trpc_pkg::ST_OK) begin
        first_err_nxt = fail_code;
      end
    end
    if (phase_nxt != phase_r) begin
      field_count_nxt = 32'd0;
      field_shift_nxt = 64'd0;
    end

    if (total_count_nxt < 32'(trpc_pkg::MIN_RECORD)) begin
      verdict_st = trpc_pkg::ST_TRUNC;
    end else if (first_err_nxt != trpc_pkg::ST_OK) begin
      verdict_st = first_err_nxt;
    end else if (phase_nxt == trpc_pkg::PH_DONE) begin
      verdict_st = trpc_pkg::ST_OK;
    end else if (phase_nxt == trpc_pkg::PH_PAYLOAD) begin
      verdict_st = trpc_pkg::ST_PAY_LEN;
    end else if (phase_nxt == trpc_pkg::PH_SIGLEN || phase_nxt == trpc_pkg::PH_SIG) begin
      verdict_st = trpc_pkg::ST_SIG_LEN;
    end else begin
      verdict_st = trpc_pkg::ST_TRUNC;
    end

    if (frame_end) begin
      res.verdict_vld      = 1'b1;
      res.nonce_value      = nonce_nxt;
      res.fee_value        = fee_nxt;
      res.payload_length   = pay_len_nxt;
      res.signature_length = sig_len_nxt;
      res.status           = verdict_st;
      phase_nxt            = trpc_pkg::PH_MAGIC;
      field_count_nxt      = 32'd0;
      total_count_nxt      = 32'd0;
      field_shift_nxt      = 64'd0;
      nonce_nxt            = 64'd0;
      fee_nxt              = 64'd0;
      pay_len_nxt          = 32'd0;
      sig_len_nxt          = 16'd0;
      first_err_nxt        = trpc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= trpc_pkg::PH_MAGIC;
      field_count_r <= 32'd0;
      total_count_r <= 32'd0;
      field_shift_r <= 64'd0;
      nonce_r       <= 64'd0;
      fee_r         <= 64'd0;
      pay_len_r     <= 32'd0;
      sig_len_r     <= 16'd0;
      first_err_r   <= trpc_pkg::ST_OK;
    end else if (take_en) begin
      phase_r       <= phase_nxt;
      field_count_r <= field_count_nxt;
      total_count_r <= total_count_nxt;
      field_shift_r <= field_shift_nxt;
      nonce_r       <= nonce_nxt;
      fee_r         <= fee_nxt;
      pay_len_r     <= pay_len_nxt;
      sig_len_r     <= sig_len_nxt;
      first_err_r   <= first_err_nxt;
    end
  end

endmodule

@@ rtl/trpc_pair_fifo.sv @@
// small register queue of result pairs between parser and output port
// depends on trpc_pkg
module trpc_pair_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  trpc_pkg::pair_t      push_data,
  input  logic                 pop,
  output trpc_pkg::pair_t      head,
  output trpc_pkg::fifo_stat_t stat
);

  localparam int unsigned DEPTH = trpc_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = trpc_pkg::FIFO_PTR_W;
  localparam int unsigned CNT_W = trpc_pkg::FIFO_CNT_W;

  trpc_pkg::pair_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = entry_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

@@ rtl/tx_record_parser_checker_top.sv @@
// Transaction record parser and checker. Takes one record byte per beat (in_tlast on the
// final byte) and streams key, payload and signature bytes, then a verdict beat with the
// decoded nonce, fee, lengths and status on the final byte. A new byte is accepted every
// cycle while the queue has room: the parser updates per accepted byte, and results wait
// in a 4-entry queue of result pairs. A byte that carries both a streamed byte and the
// verdict takes two output beats, so the output side runs at one result per cycle while
// out_tready is high. Verdict beats have out_tlast high; a nonzero status tells the
// consumer to drop the bytes streamed for that record.
// Depends on trpc_pkg, trpc_cfg_regs, trpc_parser, trpc_pair_fifo and assert_macros.svh.
`include "assert_macros.svh"

module tx_record_parser_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // frame_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_byte, [71:8] nonce_value, [135:72] fee_value, [167:136] payload_length,
  // [183:168] signature_length, [186:184] status, [191:187] zero
  output logic [191:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // last
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  trpc_pkg::cfg_t       cfg;
  trpc_pkg::pair_t      res;
  trpc_pkg::pair_t      head;
  trpc_pkg::fifo_stat_t fstat;

  logic in_fire;
  logic out_fire;
  logic push;
  logic pop;
  logic send_stream;
  logic half_r, half_nxt;

  trpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign in_tready = !fstat.full;
  assign in_fire   = in_tvalid && in_tready;

  trpc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .take_en   (in_fire),
    .data_byte (in_tdata),
    .frame_end (in_tlast),
    .res       (res)
  );

  assign push = in_fire && (res.stream_vld || res.verdict_vld);

  trpc_pair_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .pop       (pop),
    .head      (head),
    .stat      (fstat)
  );

  // a pair with both results sends the streamed byte first
  assign send_stream = head.stream_vld && !half_r;
  assign out_tvalid  = !fstat.empty;
  assign out_fire    = out_tvalid && out_tready;
  assign pop         = out_fire && (!send_stream || !head.verdict_vld);

  always_comb begin
    half_nxt = half_r;
    if (pop) begin
      half_nxt = 1'b0;
    end else if (out_fire && send_stream) begin
      half_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
    end else begin
      half_r <= half_nxt;
    end
  end

  always_comb begin
    if (send_stream) begin
      out_tdata = {184'd0, head.stream_byte};
      out_tuser = head.stream_kind;
      out_tlast = 1'b0;
    end else begin
      out_tdata = {5'd0, head.status, head.signature_length, head.payload_length,
                   head.fee_value, head.nonce_value, 8'd0};
      out_tuser = trpc_pkg::KIND_VERDICT;
      out_tlast = 1'b1;
    end
  end

  `TRPC_ASSERT(a_verdict_last, clk, rst_n,
    (out_tvalid && out_tuser == trpc_pkg::KIND_VERDICT) |-> out_tlast, "verdict without last")
  `TRPC_ASSERT(a_stream_clean, clk, rst_n,
    (out_tvalid && !out_tlast) |-> (out_tdata[191:8] == 184'd0), "streamed beat carries fields")
  `TRPC_ASSERT_NEVER(a_fifo_bound, clk, rst_n,
    fstat.count > trpc_pkg::FIFO_CNT_W'(trpc_pkg::FIFO_DEPTH), "result queue overflow")
  `TRPC_ASSERT(a_half_hold, clk, rst_n,
    half_r |-> (out_tvalid && head.stream_vld && head.verdict_vld), "split pair lost its head")

endmodule
